FILE: hdl/satl_pkg.sv
// Shared types and constants for the sorted address table lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package satl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int ADDR_W              = 64;
  localparam int CMD_W               = 2;
  localparam int IDX_W               = 11;
  localparam int OUT_TDATA_W         = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RES_PLAIN  = 2'd0,
    RES_FULL   = 2'd1,
    RES_LOOKUP = 2'd2
  } res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;       // latch key, start search over [0, count)
    logic      clear;
    logic      probe_rd;
    logic      probe_upd;
    logic      chk_rd;
    logic      chk_cmp;
    logic      shift_init;
    logic      shift_rd;
    logic      shift_wr;
    logic      put;
    logic      out_load;
    res_kind_t res;
  } satl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic search_done;
    logic lo_zero;
    logic shift_done;
  } satl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_address_table_lookup_unit.sv
// Top level of the sorted address table lookup unit.
// Keeps up to TABLE_DEPTH 64-bit addresses in ascending order in a single-port-write,
// registered-read memory and answers one command per input word with one result
// word. Clear, the unused command code and a refused insert go straight from idle to
// the done state. Every other insert and every lookup runs an upper-bound binary
// search with one memory read per probe and makes at most ceil(log2(count+1))
// probes before the bounds meet. A lookup that ends above entry 0 then reads back
// the entry before the bound to see whether it matches the key. An insert instead
// moves every entry at and above its position up by one, one read and one write per
// entry, and then writes the new address at its position. Each command ends in the
// done state, which loads the result register once the output register is free. A
// new command is taken only while the unit is idle; a finished result waits in the
// output register while the next command is taken, but that command cannot load its
// result until the output register is free. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_address_table_lookup_unit
  import satl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [ADDR_W-1:0]      s_tdata,  // [63:0] address
  input  wire logic [CMD_W-1:0]       s_tuser,  // [1:0] command
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata   // [10:0] index, [11] found,
                                                // [22:12] entry_count, [23] status
);

  satl_cmd_t        cmd;
  satl_sts_t        sts;
  logic [IDX_W-1:0] index;
  logic             found;
  logic [IDX_W-1:0] entry_count;
  logic             status;

  satl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  satl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .address     (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .index       (index),
    .found       (found),
    .entry_count (entry_count),
    .status      (status)
  );

  assign m_tdata = {status, entry_count, found, index};

endmodule

`default_nettype wire

FILE: hdl/satl_ctrl.sv
// Controller state machine for the sorted address table lookup unit.
`timescale 1ns / 1ps
`default_nettype none

module satl_ctrl
  import satl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [CMD_W-1:0] command,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output satl_cmd_t             cmd,
  input  wire satl_sts_t        sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_DONE
  } state_t;

  state_t    state, state_next;
  logic      is_insert, is_insert_next;
  res_kind_t res_kind, res_kind_next;
  logic      out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next     = state;
    is_insert_next = is_insert;
    res_kind_next  = res_kind;
    cmd            = '0;
    cmd.res        = res_kind;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (command)
            CMD_CLEAR: begin
              cmd.clear     = 1'b1;
              res_kind_next = RES_PLAIN;
              state_next    = ST_DONE;
            end
            CMD_INSERT: begin
              if (sts.full) begin
                res_kind_next = RES_FULL;
                state_next    = ST_DONE;
              end else begin
                is_insert_next = 1'b1;
                state_next     = ST_PROBE;
              end
            end
            CMD_LOOKUP: begin
              is_insert_next = 1'b0;
              state_next     = ST_PROBE;
            end
            default: begin
              res_kind_next = RES_PLAIN;
              state_next    = ST_DONE;
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (sts.search_done) begin
          if (is_insert) begin
            cmd.shift_init = 1'b1;
            state_next     = ST_SHIFT_RD;
          end else if (sts.lo_zero) begin
            res_kind_next = RES_LOOKUP;
            state_next    = ST_DONE;
          end else begin
            state_next = ST_CHK_RD;
          end
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.probe_upd = 1'b1;
        state_next    = ST_PROBE;
      end
      ST_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_next = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        cmd.chk_cmp   = 1'b1;
        res_kind_next = RES_LOOKUP;
        state_next    = ST_DONE;
      end
      ST_SHIFT_RD: begin
        if (sts.shift_done) begin
          state_next = ST_PUT;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SHIFT_RD;
      end
      ST_PUT: begin
        cmd.put       = 1'b1;
        res_kind_next = RES_PLAIN;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      is_insert <= 1'b0;
      res_kind  <= RES_PLAIN;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      is_insert <= is_insert_next;
      res_kind  <= res_kind_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/satl_dpath.sv
// Datapath: address memory, search bounds, shift pointer and result register.
`timescale 1ns / 1ps
`default_nettype none

module satl_dpath
  import satl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] address,
  input  wire satl_cmd_t         cmd,
  output satl_sts_t              sts,
  output logic [IDX_W-1:0]       index,
  output logic                   found,
  output logic [IDX_W-1:0]       entry_count,
  output logic                   status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rdata;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [ADDR_W-1:0] wdata;
  logic              we;

  logic [CW-1:0]     count;
  logic [CW-1:0]     lo, hi, sp;
  logic [CW-1:0]     mid, lo_m1, sp_m1;
  logic [ADDR_W-1:0] key;
  logic              hit;

  assign mid   = lo + ((hi - lo) >> 1);
  assign lo_m1 = lo - 1'b1;
  assign sp_m1 = sp - 1'b1;

  assign sts.full        = (count == CW'(TABLE_DEPTH));
  assign sts.search_done = (lo >= hi);
  assign sts.lo_zero     = (lo == '0);
  assign sts.shift_done  = (sp == lo);

  always_comb begin
    if (cmd.probe_rd) begin
      raddr = mid[AW-1:0];
    end else if (cmd.chk_rd) begin
      raddr = lo_m1[AW-1:0];
    end else begin
      raddr = sp_m1[AW-1:0];
    end
  end

  // shift moves entry sp-1 up to sp; the final put drops the key at lo
  assign we    = cmd.shift_wr || cmd.put;
  assign waddr = cmd.put ? lo[AW-1:0] : sp[AW-1:0];
  assign wdata = cmd.put ? key : rdata;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.put) begin
      count <= count + 1'b1;
    end
  end

  // search finds the first entry above key (upper bound)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= address;
      lo  <= '0;
      hi  <= count;
      hit <= 1'b0;
    end else begin
      if (cmd.probe_upd) begin
        if (rdata <= key) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      if (cmd.chk_cmp) begin
        hit <= (rdata == key);
      end
    end
    if (cmd.shift_init) begin
      sp <= count;
    end else if (cmd.shift_wr) begin
      sp <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      entry_count <= IDX_W'(count);
      case (cmd.res)
        RES_FULL: begin
          index  <= '0;
          found  <= 1'b0;
          status <= 1'b1;
        end
        RES_LOOKUP: begin
          index  <= hit ? IDX_W'(lo_m1) : IDX_W'(lo);
          found  <= hit;
          status <= 1'b0;
        end
        default: begin
          index  <= '0;
          found  <= 1'b0;
          status <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/satl_checker.sv
// Port-level checker for the sorted address table lookup unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module satl_checker
  import satl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [IDX_W-1:0] chk_index;
  logic             chk_found;
  logic [IDX_W-1:0] chk_count;
  logic             chk_status;

  assign chk_index  = m_tdata[IDX_W-1:0];
  assign chk_found  = m_tdata[IDX_W];
  assign chk_count  = m_tdata[2*IDX_W:IDX_W+1];
  assign chk_status = m_tdata[2*IDX_W+1];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one command in flight: accepting a word closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again while a command is in flight");

  // a refused insert reports a full table and no lookup fields
  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_status |->
      !chk_found && (chk_index == '0) && (chk_count == IDX_W'(TABLE_DEPTH)))
    else $error("refused insert with inconsistent result fields");

  // a hit points inside the held entries (not checked when TABLE_DEPTH exceeds 2047)
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_found |-> (TABLE_DEPTH > 2047) || (chk_index < chk_count))
    else $error("hit index outside the held entries");

endmodule

bind sorted_address_table_lookup_unit satl_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_satl_checker (.*);

`default_nettype wire
